FILE: hw/rtl/prplb_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// prplb_pkg
// Shared types and constants for the pointer list builder.
// -----------------------------------------------------------------------------
package prplb_pkg;

   localparam int MAX_TRANSFER_BYTES = 4194304;
   localparam int MAX_PAGE_SHIFT     = 16;
   localparam int MIN_PAGE_SHIFT     = 12;

   localparam int ADDR_W  = 64;
   localparam int LEN_W   = 23;
   localparam int LEFT_W  = 24;
   localparam int SHIFT_W = 5;
   localparam int KIND_W  = 2;
   localparam int PS_W    = MAX_PAGE_SHIFT + 1;        // holds the page size itself
   localparam int IDX_W   = MAX_PAGE_SHIFT - 3 + 1;    // entries per page, inclusive
   localparam int ENTRY_BYTES_LOG2 = 3;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SHIFT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIST_BASE  = 1'd1;

   localparam logic [KIND_W-1:0] KIND_CMD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd2;

   localparam logic OPER_START   = 1'b0;
   localparam logic OPER_ADVANCE = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              operation;
      logic [ADDR_W-1:0] buffer_addr;
      logic [LEN_W-1:0]  xfer_len;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] word_addr;
      logic [ADDR_W-1:0] word_data;
      logic              more_pending;
      logic              last;
   } rsp_type;

   // work handed from front to back
   typedef enum logic [1:0] {
      OP_CMD   = 2'd0,
      OP_ENTRY = 2'd1,
      OP_CHAIN = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] addr;   // chain: new list page
      logic [ADDR_W-1:0] data;   // chain: data entry value
      logic [ADDR_W-1:0] aux;    // chain: displaced entry value
      logic              more;
   } qent_type;

   typedef struct packed {
      logic     valid;
      qent_type entry;
   } qpush_type;

endpackage

FILE: hw/rtl/prplb_front.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// prplb_front
// Accepts items, keeps the transfer state and registers, and queues work.
// -----------------------------------------------------------------------------
module prplb_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  prplb_pkg::req_type                      req_item,
   input  logic                                    accept,
   input  logic                                    csr_we,
   input  logic [prplb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [prplb_pkg::ADDR_W-1:0]            csr_data,
   output prplb_pkg::qpush_type                    push
);
   import prplb_pkg::*;

   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [ADDR_W-1:0]  next_page_ff, next_page_in;
   logic [LEFT_W-1:0]  left_ff, left_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]  list_page_ff, list_page_in;
   logic [ADDR_W-1:0]  last_val_ff, last_val_in;
   logic               active_ff, active_in;

   logic [SHIFT_W-1:0] sh;
   logic [PS_W-1:0]    ps, first;
   logic [LEN_W-1:0]   len, rem;
   logic [ADDR_W-1:0]  addr2, new_page, entry_addr;
   logic               page_full, fits_first, fits_second, last_page;
   qent_type           ent;

   always_comb begin
      sh = shift_ff;
      if (shift_ff < SHIFT_W'(MIN_PAGE_SHIFT)) sh = SHIFT_W'(MIN_PAGE_SHIFT);
      if (shift_ff > SHIFT_W'(MAX_PAGE_SHIFT)) sh = SHIFT_W'(MAX_PAGE_SHIFT);
      ps = PS_W'(1) << sh;
   end

   // start arithmetic
   assign first = ps - (req_item.buffer_addr[PS_W-1:0] & (ps - PS_W'(1)));
   assign len   = (req_item.xfer_len > LEN_W'(MAX_TRANSFER_BYTES))
                ? LEN_W'(MAX_TRANSFER_BYTES) : req_item.xfer_len;
   assign fits_first  = len <= LEN_W'(first);
   assign rem         = len - LEN_W'(first);
   assign fits_second = rem <= LEN_W'(ps);
   assign addr2       = req_item.buffer_addr + ADDR_W'(first);

   // advance arithmetic
   assign page_full  = idx_ff == IDX_W'(ps >> ENTRY_BYTES_LOG2);
   assign new_page   = list_page_ff + ADDR_W'(ps);
   assign entry_addr = list_page_ff + (ADDR_W'(idx_ff) << ENTRY_BYTES_LOG2);
   assign last_page  = left_ff <= LEFT_W'(ps);

   always_comb begin
      shift_in     = shift_ff;
      base_in      = base_ff;
      next_page_in = next_page_ff;
      left_in      = left_ff;
      idx_in       = idx_ff;
      list_page_in = list_page_ff;
      last_val_in  = last_val_ff;
      active_in    = active_ff;
      ent          = '0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_PAGE_SHIFT: shift_in = csr_data[SHIFT_W-1:0];
            CSR_LIST_BASE:  base_in  = csr_data;
            default: ;
         endcase
      end

      if (accept) begin
         if (req_item.operation == OPER_START) begin
            ent.op   = OP_CMD;
            ent.addr = req_item.buffer_addr;
            active_in = 1'b0;
            if (fits_first) begin
               ent.data = '0;
            end else if (fits_second) begin
               ent.data = addr2;
            end else begin
               ent.data     = base_ff;
               active_in    = 1'b1;
               next_page_in = addr2;
               left_in      = LEFT_W'(rem);
               idx_in       = '0;
               list_page_in = base_ff;
               last_val_in  = '0;
            end
            ent.more = active_in;
         end else if (!active_ff) begin
            ent.op = OP_NONE;
         end else begin
            ent.data     = next_page_ff;
            last_val_in  = next_page_ff;
            next_page_in = next_page_ff + ADDR_W'(ps);
            if (last_page) begin
               left_in   = '0;
               active_in = 1'b0;
            end else begin
               left_in   = left_ff - LEFT_W'(ps);
            end
            ent.more = active_in;
            if (page_full) begin
               ent.op       = OP_CHAIN;
               ent.addr     = new_page;
               ent.aux      = last_val_ff;
               list_page_in = new_page;
               idx_in       = IDX_W'(2);
            end else begin
               ent.op   = OP_ENTRY;
               ent.addr = entry_addr;
               idx_in   = idx_ff + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= SHIFT_W'(MIN_PAGE_SHIFT);
         base_ff      <= '0;
         next_page_ff <= '0;
         left_ff      <= '0;
         idx_ff       <= '0;
         list_page_ff <= '0;
         last_val_ff  <= '0;
         active_ff    <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         base_ff      <= base_in;
         next_page_ff <= next_page_in;
         left_ff      <= left_in;
         idx_ff       <= idx_in;
         list_page_ff <= list_page_in;
         last_val_ff  <= last_val_in;
         active_ff    <= active_in;
      end
   end

   assign push.valid = accept & req_valid;
   assign push.entry = ent;

endmodule

FILE: hw/rtl/prplb_queue.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// prplb_queue
// Short work queue between front and back.
// -----------------------------------------------------------------------------
module prplb_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  prplb_pkg::qpush_type  push,
   input  logic                  pop,
   output logic                  full,
   output logic                  nonempty,
   output prplb_pkg::qent_type   head
);
   import prplb_pkg::*;

   qent_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign full     = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign nonempty = cnt_ff != '0;
   assign head     = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push.valid ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push.valid) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) slot_ff[wr_ff] <= push.entry;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push.valid)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !nonempty |-> !pop)
      else $error("queue pop while empty");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

FILE: hw/rtl/prplb_back.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// prplb_back
// Turns queued work into result items; sequences the three chain writes.
// -----------------------------------------------------------------------------
module prplb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_nonempty,
   input  prplb_pkg::qent_type  q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output prplb_pkg::rsp_type   rsp_item
);
   import prplb_pkg::*;

   typedef enum logic [2:0] {
      ST_PASS = 3'b001,
      ST_SLOT = 3'b010,
      ST_DATA = 3'b100
   } state_type;

   localparam logic [ADDR_W-1:0] ENTRY_BYTES = ADDR_W'(1) << ENTRY_BYTES_LOG2;

   state_type state_ff, state_in;
   qent_type  hold_ff, hold_in;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_ff, out_in;
   logic      out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      hold_in      = hold_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      q_pop        = 1'b0;

      if (out_free) begin
         unique case (state_ff)
            ST_PASS: begin
               if (q_nonempty) begin
                  q_pop        = 1'b1;
                  out_valid_in = 1'b1;
                  out_in.word_addr    = q_head.addr;
                  out_in.word_data    = q_head.data;
                  out_in.more_pending = q_head.more;
                  out_in.last         = 1'b1;
                  case (q_head.op)
                     OP_CMD:   out_in.kind = KIND_CMD;
                     OP_ENTRY: out_in.kind = KIND_ENTRY;
                     OP_CHAIN: begin
                        out_in.kind         = KIND_ENTRY;
                        out_in.word_data    = q_head.aux;
                        out_in.more_pending = 1'b1;
                        out_in.last         = 1'b0;
                        hold_in             = q_head;
                        state_in            = ST_SLOT;
                     end
                     default:  out_in.kind = KIND_NONE;
                  endcase
               end
            end
            ST_SLOT: begin
               out_valid_in        = 1'b1;
               out_in.kind         = KIND_ENTRY;
               out_in.word_addr    = hold_ff.addr - ENTRY_BYTES;
               out_in.word_data    = hold_ff.addr;
               out_in.more_pending = 1'b1;
               out_in.last         = 1'b0;
               state_in            = ST_DATA;
            end
            ST_DATA: begin
               out_valid_in        = 1'b1;
               out_in.kind         = KIND_ENTRY;
               out_in.word_addr    = hold_ff.addr + ENTRY_BYTES;
               out_in.word_data    = hold_ff.data;
               out_in.more_pending = hold_ff.more;
               out_in.last         = 1'b1;
               state_in            = ST_PASS;
            end
            default: state_in = ST_PASS;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PASS;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   a_no_pop_mid_chain: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_PASS |-> !q_pop)
      else $error("queue popped during chain sequence");

   a_chain_starts: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_head.op == OP_CHAIN |=> state_ff == ST_SLOT && !rsp_item.last)
      else $error("chain entry did not start slot sequence");

   a_data_closes: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DATA && out_free |=> rsp_valid && rsp_item.last
                                          && state_ff == ST_PASS)
      else $error("chain sequence did not close with last item");

endmodule

FILE: hw/rtl/prp_list_builder_core.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// prp_list_builder_core
// Builds the two data pointers and the pointer list writes for one transfer.
// -----------------------------------------------------------------------------
//
//  channel | ports                          | direction | moves
//  --------+--------------------------------+-----------+----------------------
//  req     | req_valid, req_stall, req_item | in        | start / advance item
//  rsp     | rsp_valid, rsp_stall, rsp_item | out       | pointer or list write
//  csr     | csr_valid, csr_ready, csr_index| in        | register write
//          | csr_data                       |           |
//
//  Flow: one item per cycle in while req_stall is low; a start, an advance or
//  an idle advance gives one result, held first in the queue and then in the
//  output register. An advance that fills a list page gives three results; a
//  four-entry queue between the front and the back absorbs the difference, and
//  req_stall rises only when that queue is full.
//  Reset: synchronous, clears the transfer state (no list pending), sets
//  page_shift to 12 and list_base to 0.
//  Stalls: rsp_stall holds the output register; results already queued wait.
// -----------------------------------------------------------------------------
module prp_list_builder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  prplb_pkg::req_type                  req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output prplb_pkg::rsp_type                  rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [prplb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [prplb_pkg::ADDR_W-1:0]        csr_data
);
   import prplb_pkg::*;

   qpush_type push;
   qent_type  head;
   logic      q_full, q_nonempty, q_pop, accept;

   // take an item whenever the queue has room
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   // the user must write only while idle; the block does not enforce it and always takes them
   assign csr_ready = 1'b1;

   prplb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .accept    (accept),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .push      (push)
   );

   prplb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (q_pop),
      .full     (q_full),
      .nonempty (q_nonempty),
      .head     (head)
   );

   // drain queued work into the output register
   prplb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_nonempty (q_nonempty),
      .q_head     (head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule

FILE: test/tb_prp_list_builder_core.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_prp_list_builder_core
// Self-checking bench for the data pointer and pointer list builder.
// -----------------------------------------------------------------------------
// A queue of start and advance items feeds a clocked driver. At every accepted
// item, an in-bench model of the transfer state works out the pointer and
// list-entry writes that the block owes, in order. A clocked monitor pops one
// owed write per accepted result and compares it field by field.
//
// The directed part walks the short, one-page-follows, list, wrap, over-long,
// abandon and idle-advance cases. Random transfers follow under six register
// settings (page sizes clamped from both sides, list bases at zero and near
// the top of the address space).
// -----------------------------------------------------------------------------
module tb_prp_list_builder_core;
   import prplb_pkg::*;

   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [ADDR_W-1:0]    data;
   } csr_write_type;

   // ---------------------------------------------------------------------------
   // Clock, reset and block ports
   // ---------------------------------------------------------------------------
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_item = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_item;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ADDR_W-1:0]  csr_data = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   prp_list_builder_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ---------------------------------------------------------------------------
   // Bench bookkeeping
   // ---------------------------------------------------------------------------
   req_type       pending_items[$];
   csr_write_type pending_csr[$];
   rsp_type       due_writes[$];

   int unsigned items_queued = 0;
   int unsigned items_taken  = 0;
   int unsigned csr_queued   = 0;
   int unsigned csr_taken    = 0;
   int unsigned mismatches   = 0;
   int unsigned cycles       = 0;

   // idle rates in percent; changed only while the block is quiet
   int unsigned send_gap_pct   = 0;
   int unsigned recv_stall_pct = 0;

   // ---------------------------------------------------------------------------
   // Transfer model: registers and list state as the block should hold them
   // ---------------------------------------------------------------------------
   logic [SHIFT_W-1:0] cfg_page_shift = 5'd12;
   logic [ADDR_W-1:0]  cfg_list_base  = '0;

   logic [ADDR_W-1:0]  tx_next_page  = '0;
   logic [LEFT_W-1:0]  tx_bytes_left = '0;
   logic [IDX_W-1:0]   tx_slot       = '0;
   logic [ADDR_W-1:0]  tx_list_page  = '0;
   logic [ADDR_W-1:0]  tx_last_value = '0;
   logic               tx_list_open  = 1'b0;

   function automatic void owe_write(input logic [KIND_W-1:0] kind,
                                     input logic [ADDR_W-1:0] addr,
                                     input logic [ADDR_W-1:0] data,
                                     input logic more, input logic tail);
      rsp_type w;
      w.kind         = kind;
      w.word_addr    = addr;
      w.word_data    = data;
      w.more_pending = more;
      w.last         = tail;
      due_writes.push_back(w);
   endfunction

   // Work out the writes one accepted item causes and advance the list state.
   function automatic void build_pointers(input req_type item);
      logic [SHIFT_W-1:0] sh;
      logic [ADDR_W-1:0]  ps, first, len, rem, addr2, prp2, old_page, new_page;
      logic [ADDR_W-1:0]  entry_addr, value;
      sh = cfg_page_shift;
      if (sh < MIN_PAGE_SHIFT) sh = SHIFT_W'(MIN_PAGE_SHIFT);
      if (sh > MAX_PAGE_SHIFT) sh = SHIFT_W'(MAX_PAGE_SHIFT);
      ps = 64'd1 << sh;

      if (item.operation == OPER_START) begin
         len = 64'(item.xfer_len);
         if (len > MAX_TRANSFER_BYTES) len = 64'(MAX_TRANSFER_BYTES);
         first = ps - (item.buffer_addr & (ps - 64'd1));
         tx_list_open = 1'b0;
         if (len <= first) begin
            prp2 = '0;
         end else begin
            rem   = len - first;
            addr2 = item.buffer_addr + first;
            if (rem <= ps) begin
               prp2 = addr2;
            end else begin
               // open a list: PRP2 points at the first list page
               prp2          = cfg_list_base;
               tx_list_open  = 1'b1;
               tx_next_page  = addr2;
               tx_bytes_left = LEFT_W'(rem);
               tx_slot       = '0;
               tx_list_page  = cfg_list_base;
               tx_last_value = '0;
            end
         end
         owe_write(KIND_CMD, item.buffer_addr, prp2, tx_list_open, 1'b1);
      end else if (!tx_list_open) begin
         owe_write(KIND_NONE, '0, '0, 1'b0, 1'b1);
      end else begin
         if (64'(tx_slot) == (ps >> ENTRY_BYTES_LOG2)) begin
            // page full: move the last entry to slot 0 of the next page and
            // chain to it from the old last slot
            old_page = tx_list_page;
            new_page = old_page + ps;
            owe_write(KIND_ENTRY, new_page, tx_last_value, 1'b1, 1'b0);
            owe_write(KIND_ENTRY,
                      old_page + ((64'(tx_slot) - 64'd1) << ENTRY_BYTES_LOG2),
                      new_page, 1'b1, 1'b0);
            tx_list_page = new_page;
            tx_slot      = IDX_W'(1);
         end
         entry_addr    = tx_list_page + (64'(tx_slot) << ENTRY_BYTES_LOG2);
         value         = tx_next_page;
         tx_last_value = value;
         tx_slot       = tx_slot + IDX_W'(1);
         tx_next_page  = tx_next_page + ps;
         if (64'(tx_bytes_left) <= ps) begin
            tx_bytes_left = '0;
            tx_list_open  = 1'b0;
         end else begin
            tx_bytes_left = tx_bytes_left - LEFT_W'(ps);
         end
         owe_write(KIND_ENTRY, entry_addr, value, tx_list_open, 1'b1);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
   endtask

   // ---------------------------------------------------------------------------
   // Item driver: predict on acceptance, then offer the next item or a gap
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            build_pointers(req_item);
            items_taken++;
         end
         // hold a stalled item; otherwise advance or idle
         if (!req_valid || !req_stall) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
               req_item  <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Register write driver: the model takes the value when the write lands
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      csr_write_type w;
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PAGE_SHIFT) cfg_page_shift = csr_data[SHIFT_W-1:0];
            else if (csr_index == CSR_LIST_BASE) cfg_list_base = csr_data;
            csr_taken++;
         end
         if (!csr_valid || csr_ready) begin
            if (pending_csr.size() > 0) begin
               w = pending_csr.pop_front();
               csr_index <= w.index;
               csr_data  <= w.data;
               csr_valid <= 1'b1;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result monitor: compare each accepted result with the oldest owed write
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_writes.size() == 0) begin
               report_mismatch("result with nothing owed", rsp_item.word_addr, '0);
            end else begin
               want = due_writes.pop_front();
               if (rsp_item.kind !== want.kind)
                  report_mismatch("kind", 64'(rsp_item.kind), 64'(want.kind));
               if (rsp_item.word_addr !== want.word_addr)
                  report_mismatch("word_addr", rsp_item.word_addr, want.word_addr);
               if (rsp_item.word_data !== want.word_data)
                  report_mismatch("word_data", rsp_item.word_data, want.word_data);
               if (rsp_item.more_pending !== want.more_pending)
                  report_mismatch("more_pending", 64'(rsp_item.more_pending),
                                  64'(want.more_pending));
               if (rsp_item.last !== want.last)
                  report_mismatch("last", 64'(rsp_item.last), 64'(want.last));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[%0t] timeout: %0d of %0d items taken, %0d writes owed",
                  $time, items_taken, items_queued, due_writes.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic void queue_item(input logic op, input logic [63:0] addr,
                                      input logic [63:0] len);
      req_type r;
      r.operation   = op;
      r.buffer_addr = addr;
      r.xfer_len    = LEN_W'(len);
      pending_items.push_back(r);
      items_queued++;
   endfunction

   // advance items ignore address and length; fill them with noise anyway
   function automatic void queue_advances(input int unsigned count);
      for (int unsigned k = 0; k < count; k++)
         queue_item(OPER_ADVANCE, rand_word(), 64'($urandom));
   endfunction

   function automatic void queue_csr(input logic [CSR_IDX_W-1:0] index,
                                     input logic [63:0] data);
      csr_write_type w;
      w.index = index;
      w.data  = data;
      pending_csr.push_back(w);
      csr_queued++;
   endfunction

   // One start with mostly enough advances to finish its list; some end early
   // (abandoned by the next start) or run past the end (idle advances).
   function automatic int unsigned queue_random_transfer(input int unsigned shift);
      logic [63:0] ps, addr, first, len, eff_len, rem;
      int unsigned pick, pages, steps;
      ps   = 64'd1 << shift;
      addr = rand_word();
      pick = $urandom_range(99);
      if (pick < 25) addr = addr & ~(ps - 64'd1);
      else if (pick < 40) addr = addr | (ps - 64'($urandom_range(1, 64)));
      first = ps - (addr & (ps - 64'd1));

      pick = $urandom_range(99);
      if (pick < 10) len = 64'($urandom_range(0, 32'(first)));
      else if (pick < 25) len = first + 64'($urandom_range(1, 32'(ps)));
      else if (pick < 85) len = first + ps + 64'($urandom_range(1, 20 * 32'(ps)));
      else len = 64'($urandom_range(0, 32'h7F_FFFF));

      eff_len = (len > MAX_TRANSFER_BYTES) ? 64'(MAX_TRANSFER_BYTES) : len;
      pages   = 0;
      if (eff_len > first) begin
         rem = eff_len - first;
         if (rem > ps) pages = 32'((rem + ps - 64'd1) >> shift);
      end

      pick = $urandom_range(99);
      if (pick < 70) steps = pages + $urandom_range(0, 1);
      else if (pick < 90) steps = $urandom_range(0, pages);
      else steps = $urandom_range(0, 3);
      if (steps > 30) steps = $urandom_range(20, 30);

      queue_item(OPER_START, addr, len);
      queue_advances(steps);
      return 1 + steps;
   endfunction

   // Wait until every queued item and write has landed and every owed result
   // has come back, then let the pipeline drain.
   task automatic settle();
      while (items_taken != items_queued || csr_taken != csr_queued ||
             due_writes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      logic [63:0] a;
      int unsigned phase_eff[6];
      logic [63:0] phase_ps_word[6];
      logic [63:0] phase_base[6];
      int unsigned count;

      // hold reset at start, then release it for good
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part, 4 KiB pages ----------------------------------------
      send_gap_pct   = 18;
      recv_stall_pct = 53;
      queue_csr(CSR_PAGE_SHIFT, 64'd12);
      queue_csr(CSR_LIST_BASE, 64'h0000_0040_0000_0000);
      settle();

      a = 64'h0000_1234_5678_9100;             // 0xF00 bytes left in its page
      queue_advances(1);                        // idle advance, nothing pending
      queue_item(OPER_START, '0, '0);           // zero length
      queue_item(OPER_START, '1, '0);           // zero length at top of space
      queue_item(OPER_START, a, 64'h0F00);      // ends exactly at page end
      queue_item(OPER_START, a, 64'h0F01);      // one byte spills over
      queue_item(OPER_START, a, 64'h1F00);      // exactly one page follows
      queue_item(OPER_START, a, 64'h1F01);      // smallest list: two entries
      queue_advances(3);                        // last one finds no list
      queue_item(OPER_START, a, 64'h3000);
      queue_advances(1);
      // abandon the list; the new buffer crosses the top and wraps to zero
      queue_item(OPER_START, 64'hFFFF_FFFF_FFFF_F800, 64'h2000);
      queue_advances(3);
      queue_item(OPER_START, rand_word(), 64'h7F_FFFF);   // over-long length
      queue_advances(2);
      queue_item(OPER_START, a, 64'h10);        // drop the long list
      queue_advances(1);
      settle();

      // ---- random part: six register settings, three idling modes ------------
      // page shift written below the range, above it and with junk upper bits
      phase_eff     = '{12, 13, 16, 16, 12, 14};
      phase_ps_word = '{64'd12, {rand_word() & 64'hFFFF_FFFF_FFFF_FFE0} | 64'd13,
                        '1, 64'd16, 64'd0, 64'd14};
      phase_base    = '{rand_word() & ~64'hFFF, 64'hFFFF_FFFF_FFFF_E000,
                        64'hFFFF_FFFF_FFFF_0000, '1, '0, rand_word()};

      for (int p = 0; p < 6; p++) begin
         case (p / 2)
            0: begin
               send_gap_pct   = 18;
               recv_stall_pct = 53;
            end
            1: begin
               send_gap_pct   = 53;
               recv_stall_pct = 18;
            end
            default: begin
               send_gap_pct   = 0;
               recv_stall_pct = 0;
            end
         endcase
         queue_csr(CSR_PAGE_SHIFT, phase_ps_word[p]);
         queue_csr(CSR_LIST_BASE, phase_base[p]);
         settle();

         count = 0;
         while (count < 46) begin
            count += queue_random_transfer(phase_eff[p]);
         end
         settle();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
